// ===== rtl/core/msrt_pkg.sv =====
// ----------------------------------------------------------------------------
// msrt_pkg: shared types and constants of the merge sorter
// Word layouts of the input and result channels and the default capacity.
// ----------------------------------------------------------------------------
package msrt_pkg;

    // Width of one data value.
    localparam int DATA_W = 32;

    // Default number of values kept per data set.
    localparam int MAX_ITEMS_DEF = 64;

    // Input word: one value of the set and the end-of-set mark.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_word_t;

    // Result word: one sorted value with its end mark and overflow flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_word_t;

endpackage

// ===== rtl/core/msrt_bank.sv =====
// ----------------------------------------------------------------------------
// msrt_bank: value storage bank of the merge sorter
// One write port and two registered read ports over a small array.
// ----------------------------------------------------------------------------
module msrt_bank #(
    parameter int ADDR_W = $clog2(msrt_pkg::MAX_ITEMS_DEF)
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [msrt_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                 rd_addr_a,
    input  logic [ADDR_W-1:0]                 rd_addr_b,
    output logic signed [msrt_pkg::DATA_W-1:0] rd_data_a,
    output logic signed [msrt_pkg::DATA_W-1:0] rd_data_b
);
    import msrt_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/merge_sorter.sv =====
// ----------------------------------------------------------------------------
// merge_sorter: bottom-up merge sort of a set of signed 32-bit values
// Collects a set, sorts it in two ping-pong banks and streams it out.
// ----------------------------------------------------------------------------
// A set of n values is taken one word per cycle until a word carries last;
// words beyond MAX_ITEMS are dropped and flag overflow on every result of
// that set. The sort then runs ceil(log2(n)) merge passes between two banks.
// Each pass merges each pair of runs in S_MERGE, one merged value at a
// time from the single compare unit, after a setup state S_RUN for that
// pair. A drain state S_DRAIN then primes the read port, after which the
// sorted values leave at one word per cycle while m_ready is high. The
// input is not ready from the last word of a set until its final result has
// been taken.
module merge_sorter #(
    parameter int MAX_ITEMS = msrt_pkg::MAX_ITEMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msrt_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output msrt_pkg::out_word_t m_data
);
    import msrt_pkg::*;

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int PW     = CNT_W + 2;

    // Sequencer states.
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic             src_sel_reg, src_sel_next;
    logic [PW-1:0]    width_reg, width_next;
    logic [PW-1:0]    start_reg, start_next;
    logic [PW-1:0]    mid_reg, mid_next;
    logic [PW-1:0]    end_reg, end_next;
    logic [PW-1:0]    i_reg, i_next;
    logic [PW-1:0]    j_reg, j_next;
    logic [PW-1:0]    k_reg, k_next;

    logic [PW-1:0]    n_ext;
    logic [PW-1:0]    run_mid;
    logic [PW-1:0]    run_end;
    logic [PW-1:0]    width_dbl;
    logic             s_fire;
    logic             m_fire;
    logic             has_room;
    logic             out_last;

    logic                     a_live;
    logic                     b_live;
    logic                     take_a;
    logic                     k_last;
    logic signed [DATA_W-1:0] head_a;
    logic signed [DATA_W-1:0] head_b;
    logic signed [DATA_W-1:0] merged;

    logic                     wr0_en, wr1_en;
    logic [ADDR_W-1:0]        wr0_addr;
    logic signed [DATA_W-1:0] wr0_data;
    logic [ADDR_W-1:0]        rd_addr_a, rd_addr_b;
    logic signed [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

    // Handshakes and derived run bounds.
    assign s_ready   = (state_reg == S_LOAD);
    assign m_valid   = (state_reg == S_OUT);
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign has_room  = (count_reg < CNT_W'(MAX_ITEMS));
    assign n_ext     = {{(PW - CNT_W){1'b0}}, count_reg};
    assign width_dbl = width_reg << 1;
    assign run_mid   = ((start_reg + width_reg) > n_ext) ? n_ext : (start_reg + width_reg);
    assign run_end   = ((start_reg + width_dbl) > n_ext) ? n_ext : (start_reg + width_dbl);
    assign out_last  = ((i_reg + 1'b1) == n_ext);

    // Shared compare unit: pick the smaller head of the two runs.
    assign head_a = src_sel_reg ? rd1_a : rd0_a;
    assign head_b = src_sel_reg ? rd1_b : rd0_b;
    assign a_live = (i_reg < mid_reg);
    assign b_live = (j_reg < end_reg);
    assign take_a = a_live && (!b_live || (head_a < head_b));
    assign merged = take_a ? head_a : head_b;
    assign k_last = ((k_reg + 1'b1) == end_reg);

    // Sequencer next state.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        src_sel_next = src_sel_reg;
        width_next   = width_reg;
        start_next   = start_reg;
        mid_next     = mid_reg;
        end_next     = end_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (has_room) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_data.last) begin
                        src_sel_next = 1'b0;
                        width_next   = PW'(1);
                        start_next   = '0;
                        if (count_next > CNT_W'(1)) begin
                            state_next = S_RUN;
                        end else begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_RUN: begin
                mid_next   = run_mid;
                end_next   = run_end;
                i_next     = start_reg;
                j_next     = run_mid;
                k_next     = start_reg;
                state_next = S_MERGE;
            end
            S_MERGE: begin
                k_next = k_reg + 1'b1;
                if (take_a) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                if (k_last) begin
                    if (end_reg >= n_ext) begin
                        width_next   = width_dbl;
                        src_sel_next = !src_sel_reg;
                        start_next   = '0;
                        if (width_dbl >= n_ext) begin
                            state_next = S_DRAIN;
                        end else begin
                            state_next = S_RUN;
                        end
                    end else begin
                        start_next = end_reg;
                        state_next = S_RUN;
                    end
                end
            end
            S_DRAIN: begin
                i_next     = '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_fire) begin
                    if (out_last) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            src_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            src_sel_reg <= src_sel_next;
        end
    end

    // Run bounds and pointers.
    always_ff @(posedge aclk) begin
        width_reg <= width_next;
        start_reg <= start_next;
        mid_reg   <= mid_next;
        end_reg   <= end_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
    end

    // Bank ports: reads follow the next pointers so the heads stay current.
    assign rd_addr_a = i_next[ADDR_W-1:0];
    assign rd_addr_b = j_next[ADDR_W-1:0];
    assign wr0_en    = (s_fire && has_room) || ((state_reg == S_MERGE) && src_sel_reg);
    assign wr1_en    = (state_reg == S_MERGE) && !src_sel_reg;
    assign wr0_addr  = (state_reg == S_MERGE) ? k_reg[ADDR_W-1:0] : count_reg[ADDR_W-1:0];
    assign wr0_data  = (state_reg == S_MERGE) ? merged : s_data.value;

    msrt_bank #(
        .ADDR_W(ADDR_W)
    ) u_bank0 (
        .aclk     (aclk),
        .wr_en    (wr0_en),
        .wr_addr  (wr0_addr),
        .wr_data  (wr0_data),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd0_a),
        .rd_data_b(rd0_b)
    );

    msrt_bank #(
        .ADDR_W(ADDR_W)
    ) u_bank1 (
        .aclk     (aclk),
        .wr_en    (wr1_en),
        .wr_addr  (k_reg[ADDR_W-1:0]),
        .wr_data  (merged),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd1_a),
        .rd_data_b(rd1_b)
    );

    // Result word.
    assign m_data.sorted_value = head_a;
    assign m_data.last_out     = out_last;
    assign m_data.overflow     = drop_reg;

    // The two channels are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
    else $error("input ready while a result is shown");

    // The merge write pointer stays inside the current run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE) |-> (k_reg < end_reg) && (i_reg <= mid_reg)
            && (j_reg <= end_reg))
    else $error("merge pointer outside its run");

    // The stored count never exceeds the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");

    // Taking the final result of a set reopens the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_data.last_out) |=> s_ready && (count_reg == '0) && !drop_reg)
    else $error("set not closed after its final result");

    // A result is only shown for a nonempty stored set, at an index inside it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (count_reg != '0) && (i_reg < n_ext))
    else $error("result index outside the stored set");

endmodule
